@@ hw/rtl/egdd_pkg.sv @@
// ----------------------------------------------------------------------------
// egdd_pkg
// Shared types, codes and helpers for the unary / gamma / delta / fixed-width
// bitstream decoder.
// ----------------------------------------------------------------------------
package egdd_pkg;

  localparam int WORD_W     = 32;
  localparam int CNT_W      = 6;   // holds 0..32
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] PREFIX_LIMIT = 6'd32;
  localparam logic [CNT_W-1:0] WORD_BITS    = 6'd32;
  localparam logic [CNT_W-1:0] MAX_FIELD    = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CODE_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    KIND_UNARY = 2'd0,
    KIND_GAMMA = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_FIELD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_SUFFIX = 2'd1,
    PH_DELTA  = 2'd2,
    PH_FIELD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_FLUSH = 2'd2
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture a new stream word
    logic step;   // decode one bit
    logic flush;  // hand the held result to the output as the word's last
  } egdd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic finished;  // decoding has stopped
    logic word_end;  // the current bit is the word's final bit
    logic pend_v;    // a result is held back waiting for its last flag
    logic out_free;  // the output register can take a result this cycle
  } egdd_stat_t;

  // A zero width reads as one, anything above 32 as 32.
  function automatic logic [CNT_W-1:0] eff_width(input logic [CNT_W-1:0] fw);
    logic [CNT_W-1:0] w;
    begin
      if (fw == '0) begin
        w = 6'd1;
      end else if (fw > MAX_FIELD) begin
        w = MAX_FIELD;
      end else begin
        w = fw;
      end
      return w;
    end
  endfunction

endpackage

@@ hw/rtl/egdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// egdd_ctrl
// Sequencer: takes one stream word, steps the datapath through its bits and
// releases the held result of the word with its last flag.
// ----------------------------------------------------------------------------
module egdd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egdd_pkg::egdd_stat_t stat,
  output egdd_pkg::egdd_cmd_t  cmd
);
  import egdd_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.finished) begin
          state_nxt = ST_FLUSH;
        end else if (!stat.pend_v || stat.out_free) begin
          // A bit may produce a result that pushes the held one out, so
          // only step when the output can take it.
          cmd.step = 1'b1;
          if (stat.word_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/egdd_dp.sv @@
// ----------------------------------------------------------------------------
// egdd_dp
// Datapath: configuration registers, word shifter, one-bit decode step,
// held result and output register.
// ----------------------------------------------------------------------------
module egdd_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  egdd_pkg::egdd_cmd_t                   cmd,
  output egdd_pkg::egdd_stat_t                  stat,
  input  logic                                  cfg_write_en,
  input  logic [egdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [egdd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [egdd_pkg::WORD_W-1:0]           in_data_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [egdd_pkg::WORD_W-1:0]           out_value,
  output logic                                  out_last,
  output logic                                  out_error,
  output logic                                  out_done_res
);
  import egdd_pkg::*;

  // Configuration.
  kind_t              code_kind_r, code_kind_nxt;
  logic [CNT_W-1:0]   field_width_r, field_width_nxt;
  logic [WORD_W-1:0]  value_count_r, value_count_nxt;

  // Decoder state.
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   zero_run_r, zero_run_nxt;
  logic [WORD_W-1:0]  partial_r, partial_nxt;
  logic [CNT_W-1:0]   bits_left_r, bits_left_nxt;
  logic [WORD_W-1:0]  emitted_r, emitted_nxt;
  logic               finished_r, finished_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [CNT_W-1:0]   bits_rem_r, bits_rem_nxt;

  // Held result, waiting to learn whether it is the word's last.
  logic               pend_v_r, pend_v_nxt;
  logic [WORD_W-1:0]  pend_value_r, pend_value_nxt;
  logic               pend_err_r, pend_err_nxt;
  logic               pend_done_r, pend_done_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_error_r, out_error_nxt;
  logic               out_done_r, out_done_nxt;

  logic               cfg_hit;
  logic               out_free;
  logic               bit_in;
  logic [WORD_W-1:0]  pv_sh;
  logic [WORD_W-1:0]  pv_dec;
  logic [WORD_W-1:0]  emitted_inc;
  logic [CNT_W-1:0]   zero_run_inc;
  logic               reached;
  logic               have;
  logic               err;
  logic [WORD_W-1:0]  res_value;
  phase_t             start_phase;
  logic [CNT_W-1:0]   start_bits;

  assign out_free = !out_valid_r || !out_stall;

  assign stat.finished = finished_r;
  assign stat.word_end = (bits_rem_r == 6'd1);
  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = out_free;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_error    = out_error_r;
  assign out_done_res = out_done_r;

  assign cfg_hit = cfg_write_en && ((cfg_index == REG_CODE_KIND) ||
                                    (cfg_index == REG_FIELD_WIDTH) ||
                                    (cfg_index == REG_VALUE_COUNT));

  always_comb begin
    code_kind_nxt   = code_kind_r;
    field_width_nxt = field_width_r;
    value_count_nxt = value_count_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_CODE_KIND:   code_kind_nxt   = kind_t'(cfg_data[1:0]);
        REG_FIELD_WIDTH: field_width_nxt = cfg_data[CNT_W-1:0];
        REG_VALUE_COUNT: value_count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Every new code starts from these, taken from the newest configuration.
  always_comb begin
    if (code_kind_nxt == KIND_FIELD) begin
      start_phase = PH_FIELD;
      start_bits  = eff_width(field_width_nxt);
    end else begin
      start_phase = PH_PREFIX;
      start_bits  = '0;
    end
  end

  assign bit_in       = word_r[WORD_W-1];
  assign pv_sh        = {partial_r[WORD_W-2:0], bit_in};
  assign pv_dec       = pv_sh - 32'd1;
  assign emitted_inc  = emitted_r + 32'd1;
  assign zero_run_inc = zero_run_r + 6'd1;
  assign reached      = (emitted_inc >= value_count_r);

  always_comb begin
    phase_nxt      = phase_r;
    zero_run_nxt   = zero_run_r;
    partial_nxt    = partial_r;
    bits_left_nxt  = bits_left_r;
    emitted_nxt    = emitted_r;
    finished_nxt   = finished_r;
    word_nxt       = word_r;
    bits_rem_nxt   = bits_rem_r;
    pend_v_nxt     = pend_v_r;
    pend_value_nxt = pend_value_r;
    pend_err_nxt   = pend_err_r;
    pend_done_nxt  = pend_done_r;
    have           = 1'b0;
    err            = 1'b0;
    res_value      = '0;

    if (cfg_hit) begin
      emitted_nxt   = '0;
      finished_nxt  = 1'b0;
      pend_v_nxt    = 1'b0;
      phase_nxt     = start_phase;
      zero_run_nxt  = '0;
      partial_nxt   = '0;
      bits_left_nxt = start_bits;
    end else begin
      if (cmd.load) begin
        word_nxt     = in_data_word;
        bits_rem_nxt = WORD_BITS;
        if (emitted_r >= value_count_r) begin
          finished_nxt = 1'b1;
        end
      end

      if (cmd.step) begin
        word_nxt     = {word_r[WORD_W-2:0], 1'b0};
        bits_rem_nxt = bits_rem_r - 6'd1;
        unique case (phase_r)
          PH_PREFIX: begin
            if (!bit_in) begin
              zero_run_nxt = zero_run_inc;
              if (zero_run_inc >= PREFIX_LIMIT) begin
                err = 1'b1;
              end
            end else if ((code_kind_r == KIND_UNARY) || (zero_run_r == '0)) begin
              have      = 1'b1;
              res_value = {{(WORD_W-CNT_W){1'b0}}, zero_run_r};
            end else begin
              phase_nxt     = PH_SUFFIX;
              bits_left_nxt = zero_run_r;
              partial_nxt   = 32'd1;
            end
          end
          PH_SUFFIX: begin
            partial_nxt   = pv_sh;
            bits_left_nxt = bits_left_r - 6'd1;
            if (bits_left_r == 6'd1) begin
              if (code_kind_r != KIND_DELTA) begin
                have      = 1'b1;
                res_value = pv_dec;
              end else if (|pv_dec[WORD_W-1:5]) begin
                // A delta length of 32 or more cannot be represented.
                err = 1'b1;
              end else if (pv_dec == '0) begin
                have = 1'b1;
              end else begin
                phase_nxt     = PH_DELTA;
                bits_left_nxt = pv_dec[CNT_W-1:0];
                partial_nxt   = 32'd1;
              end
            end
          end
          PH_DELTA: begin
            partial_nxt   = pv_sh;
            bits_left_nxt = bits_left_r - 6'd1;
            if (bits_left_r == 6'd1) begin
              have      = 1'b1;
              res_value = pv_dec;
            end
          end
          PH_FIELD: begin
            partial_nxt = pv_sh;
            if (bits_left_r != '0) begin
              bits_left_nxt = bits_left_r - 6'd1;
            end
            if (bits_left_r <= 6'd1) begin
              have      = 1'b1;
              res_value = pv_sh;
            end
          end
          default: ;
        endcase

        if (err) begin
          pend_v_nxt     = 1'b1;
          pend_value_nxt = '0;
          pend_err_nxt   = 1'b1;
          pend_done_nxt  = 1'b0;
          finished_nxt   = 1'b1;
        end else if (have) begin
          emitted_nxt    = emitted_inc;
          pend_v_nxt     = 1'b1;
          pend_value_nxt = res_value;
          pend_err_nxt   = 1'b0;
          pend_done_nxt  = reached;
          if (reached) begin
            finished_nxt = 1'b1;
          end else begin
            phase_nxt     = start_phase;
            zero_run_nxt  = '0;
            partial_nxt   = '0;
            bits_left_nxt = start_bits;
          end
        end
      end

      if (cmd.flush) begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  // A new result in the same word proves the held one was not the last.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;
    out_done_nxt  = out_done_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_v_r && ((cmd.step && (have || err)) || cmd.flush)) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = pend_value_r;
      out_last_nxt  = cmd.flush;
      out_error_nxt = pend_err_r;
      out_done_nxt  = pend_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_kind_r   <= KIND_GAMMA;
      field_width_r <= MAX_FIELD;
      value_count_r <= 32'd1;
      phase_r       <= PH_PREFIX;
      zero_run_r    <= '0;
      partial_r     <= '0;
      bits_left_r   <= '0;
      emitted_r     <= '0;
      finished_r    <= 1'b0;
      bits_rem_r    <= '0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      code_kind_r   <= code_kind_nxt;
      field_width_r <= field_width_nxt;
      value_count_r <= value_count_nxt;
      phase_r       <= phase_nxt;
      zero_run_r    <= zero_run_nxt;
      partial_r     <= partial_nxt;
      bits_left_r   <= bits_left_nxt;
      emitted_r     <= emitted_nxt;
      finished_r    <= finished_nxt;
      bits_rem_r    <= bits_rem_nxt;
      pend_v_r      <= pend_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    pend_value_r <= pend_value_nxt;
    pend_err_r   <= pend_err_nxt;
    pend_done_r  <= pend_done_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_error_r  <= out_error_nxt;
    out_done_r   <= out_done_nxt;
  end

  // A step must never overwrite a held result the output cannot take.
  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!pend_v_r || out_free))
    else $error("decode step while held result is blocked");

  a_no_step_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !finished_r)
    else $error("decode step after decoding stopped");

  // Decoding stops on an error or on the final value, so nothing follows it.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> out_last_r)
    else $error("error beat not marked last");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("done beat not marked last");

endmodule

@@ hw/rtl/elias_gamma_delta_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// elias_gamma_delta_decoder_unit
// Bit-serial decoder for unary, gamma, delta and fixed-width codes packed
// most significant bit first in 32-bit stream words.
//
//   Channel  Direction  Handshake         Payload
//   in       input      in_valid/stall    in_data_word
//   out      output     out_valid/stall   out_value, out_last, out_error,
//                                         out_done_res
//   cfg      input      cfg_write_en      cfg_index, cfg_data
//
// A word is accepted in the idle state and stepped bit by bit through the
// single shared decode step; its final result goes out with the last flag in
// the flush state. A word arriving after decoding stopped is not stepped.
// Output stalls hold the decode step only while a finished result is waiting.
// Reset is synchronous and active low; any register write restarts decoding.
// ----------------------------------------------------------------------------
module elias_gamma_delta_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [egdd_pkg::WORD_W-1:0]      in_data_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [egdd_pkg::WORD_W-1:0]      out_value,
  output logic                             out_last,
  output logic                             out_error,
  output logic                             out_done_res,
  input  logic                             cfg_write_en,
  input  logic [egdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [egdd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import egdd_pkg::*;

  egdd_cmd_t  cmd;
  egdd_stat_t stat;

  egdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  egdd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error),
    .out_done_res (out_done_res)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unary / gamma / delta / fixed-width decoder.
// A bit-serial predictor in the tracker class works out the results of every
// accepted stream word. Each result beat is checked against the oldest of them.
// Stimulus is a directed set of corner cases, then random phases of encoded
// streams with some noise and broken codes. The input idles at random and the
// output is stalled at random.
// ----------------------------------------------------------------------------
module tb;
  import egdd_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
    logic              error;
    logic              done;
  } decoded_t;

  class code_tracker;
    kind_t             code_kind;
    logic [CNT_W-1:0]  width_reg;
    logic [31:0]       count_reg;
    phase_t            phase;
    logic [31:0]       zero_run;
    logic [31:0]       acc;
    logic [CNT_W-1:0]  bits_left;
    logic [CNT_W-1:0]  delta_len;
    logic [31:0]       emitted;
    bit                stopped;
    decoded_t          decoded_q[$];
    int unsigned       mismatches;
    int unsigned       words_seen;

    function new();
      code_kind  = KIND_GAMMA;
      width_reg  = 6'd32;
      count_reg  = 32'd1;
      mismatches = 0;
      words_seen = 0;
      restart();
    endfunction

    function logic [CNT_W-1:0] field_bits();
      if (width_reg == '0) return 6'd1;
      if (width_reg > 6'd32) return 6'd32;
      return width_reg;
    endfunction

    function void begin_code();
      zero_run  = '0;
      acc       = '0;
      delta_len = '0;
      if (code_kind == KIND_FIELD) begin
        phase     = PH_FIELD;
        bits_left = field_bits();
      end else begin
        phase     = PH_PREFIX;
        bits_left = '0;
      end
    endfunction

    function void restart();
      emitted = '0;
      stopped = 1'b0;
      begin_code();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      bit known;
      known = 1'b1;
      case (idx)
        REG_CODE_KIND:   code_kind = kind_t'(data[1:0]);
        REG_FIELD_WIDTH: width_reg = data[CNT_W-1:0];
        REG_VALUE_COUNT: count_reg = data;
        default:         known = 1'b0;
      endcase
      if (known) restart();
    endfunction

    // Walks the word bit by bit. The newest result is held back so that the
    // last flag can be put on it once the word is used up.
    function void decode_word(logic [WORD_W-1:0] word);
      decoded_t    held;
      decoded_t    r;
      bit          have_held;
      bit          got;
      bit          bad;
      logic [31:0] v;
      logic [31:0] g;
      logic        b;
      words_seen++;
      if (emitted >= count_reg) stopped = 1'b1;
      if (stopped) return;
      have_held = 1'b0;
      held = '0;
      for (int i = 31; i >= 0; i--) begin
        if (stopped) break;
        b   = word[i];
        got = 1'b0;
        bad = 1'b0;
        v   = '0;
        case (phase)
          PH_PREFIX: begin
            if (!b) begin
              zero_run++;
              if (zero_run >= 32) bad = 1'b1;
            end else if (code_kind == KIND_UNARY || zero_run == 0) begin
              v   = zero_run;
              got = 1'b1;
            end else begin
              phase     = PH_SUFFIX;
              bits_left = zero_run[CNT_W-1:0];
              acc       = 32'd1;
            end
          end
          PH_SUFFIX: begin
            acc = {acc[30:0], b};
            bits_left--;
            if (bits_left == 0) begin
              g = acc - 32'd1;
              if (code_kind != KIND_DELTA) begin
                v   = g;
                got = 1'b1;
              end else if (g >= 32) begin
                bad = 1'b1;
              end else if (g == 0) begin
                got = 1'b1;
              end else begin
                delta_len = g[CNT_W-1:0];
                bits_left = g[CNT_W-1:0];
                acc       = 32'd1;
                phase     = PH_DELTA;
              end
            end
          end
          PH_DELTA: begin
            acc = {acc[30:0], b};
            bits_left--;
            if (bits_left == 0) begin
              v   = acc - 32'd1;
              got = 1'b1;
            end
          end
          default: begin
            acc = {acc[30:0], b};
            if (bits_left != 0) bits_left--;
            if (bits_left == 0) begin
              v   = acc;
              got = 1'b1;
            end
          end
        endcase
        r = '0;
        if (bad) begin
          r.error = 1'b1;
          stopped = 1'b1;
        end else if (got) begin
          emitted++;
          r.value = v;
          r.done  = (emitted >= count_reg);
          if (r.done) stopped = 1'b1;
          else begin_code();
        end
        if (bad || got) begin
          if (have_held) decoded_q.push_back(held);
          held      = r;
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        decoded_q.push_back(held);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_decoded(logic [WORD_W-1:0] value, logic last, logic error,
                                logic done);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        flag($sformatf("unexpected result beat: value=%h last=%b error=%b done=%b",
                       value, last, error, done));
        return;
      end
      e = decoded_q.pop_front();
      if (e.value !== value || e.last !== last || e.error !== error || e.done !== done)
        flag($sformatf({"result mismatch: expected value=%h last=%b error=%b done=%b,",
                        " got value=%h last=%b error=%b done=%b"},
                       e.value, e.last, e.error, e.done, value, last, error, done));
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 40;    // pause after the last expected result
  // Longest quiet stretch in a correct run is a settle pause or one word in
  // flight behind a stalled output; this is many times that.
  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_WORDS  = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [WORD_W-1:0]     in_data_word;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_W-1:0]     out_value;
  logic                  out_last;
  logic                  out_error;
  logic                  out_done_res;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  code_tracker           sb;
  bit                    stream_bits[$];
  logic [WORD_W-1:0]     word_q[$];
  int                    burst_left = 0;
  int                    quiet = 0;
  stall_mode_t           stall_mode = STALL_NONE;
  int                    stall_left = 0;
  int unsigned           stall_tick = 0;

  elias_gamma_delta_decoder_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_error    (out_error),
    .out_done_res (out_done_res),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are checked before the new word is noted, so a word accepted on
  // the same edge can never satisfy an older result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_write_en) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall)
        sb.check_decoded(out_value, out_last, out_error, out_done_res);
      if (in_valid && !in_stall) sb.decode_word(in_data_word);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("elias_gamma_delta_decoder_unit test failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = ((stall_tick % 7) < 3);
    endcase
  end

  function automatic int top_bit(logic [31:0] x);
    int k;
    k = 0;
    for (int i = 0; i < 32; i++) if (x[i]) k = i;
    return k;
  endfunction

  function automatic void push_bits(logic [31:0] val, int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(val[i]);
  endfunction

  function automatic void push_zeros(int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(1'b0);
  endfunction

  function automatic void push_code(kind_t k, int w, logic [31:0] v);
    logic [31:0] x;
    logic [31:0] y;
    int          n;
    int          m;
    x = v + 32'd1;
    n = top_bit(x);
    case (k)
      KIND_UNARY: begin
        push_zeros(v);
        stream_bits.push_back(1'b1);
      end
      KIND_GAMMA: begin
        push_zeros(n);
        push_bits(x, n + 1);
      end
      KIND_DELTA: begin
        // The length of the suffix goes first as a gamma code.
        y = n + 1;
        m = top_bit(y);
        push_zeros(m);
        push_bits(y, m + 1);
        push_bits(x, n);
      end
      default: push_bits(v, w);
    endcase
  endfunction

  // A broken code: an over-long zero prefix, or in delta mode a length of 32
  // or more.
  function automatic void push_overflow(kind_t k);
    logic [31:0] y;
    int          m;
    if (k == KIND_DELTA && $urandom_range(0, 1) == 1) begin
      y = $urandom_range(33, 200);
      m = top_bit(y);
      push_zeros(m);
      push_bits(y, m + 1);
    end else begin
      push_zeros(32 + $urandom_range(0, 5));
    end
  endfunction

  function automatic logic [31:0] rand_value(kind_t k);
    logic [31:0] v;
    int          sel;
    sel = $urandom_range(0, 9);
    if (k == KIND_UNARY) return (sel < 8) ? $urandom_range(0, 5) : $urandom_range(0, 31);
    if (sel < 6) v = $urandom_range(0, 15);
    else if (sel < 8) v = $urandom_range(0, 65535);
    else v = $urandom;
    if (k != KIND_FIELD && v == 32'hFFFF_FFFF) v = 32'hFFFF_FFFE;
    return v;
  endfunction

  // Pads the bit stream with random bits to whole words and moves it out.
  function automatic void pack_words();
    logic [WORD_W-1:0] w;
    while (stream_bits.size() % 32 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
    word_q.delete();
    while (stream_bits.size() != 0) begin
      for (int j = 31; j >= 0; j--) w[j] = stream_bits.pop_front();
      word_q.push_back(w);
    end
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = data;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Unused bits of the narrow registers carry random data.
  task automatic configure(kind_t k, logic [CNT_W-1:0] fw, logic [31:0] count,
                           bit spare_write);
    logic [CFG_DATA_W-1:0] data;
    data      = $urandom;
    data[1:0] = k;
    write_cfg(REG_CODE_KIND, data);
    data            = $urandom;
    data[CNT_W-1:0] = fw;
    write_cfg(REG_FIELD_WIDTH, data);
    write_cfg(REG_VALUE_COUNT, count);
    if (spare_write) write_cfg(REG_UNUSED, $urandom);
  endtask

  // Sends word_q in bursts. drain_at names a beat before which the sender
  // waits until every pending result has come out.
  task automatic send_words(bit steady, int drain_at);
    int  hold;
    bit  drain;
    for (int k = 0; k < word_q.size(); k++) begin
      hold  = 0;
      drain = (k == drain_at) || (!steady && $urandom_range(0, 39) == 0);
      if (!steady) begin
        if (burst_left == 0) begin
          hold       = $urandom_range(0, 8);
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
      end
      if (hold != 0 || drain) begin
        @(negedge clk);
        in_valid = 1'b0;
        if (hold > 1) repeat (hold - 1) @(negedge clk);
        if (drain) while (sb.decoded_q.size() != 0) @(posedge clk);
      end
      @(negedge clk);
      in_valid     = 1'b1;
      in_data_word = word_q[k];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_words(bit steady, int drain_at);
    send_words(steady, drain_at);
    settle();
  endtask

  task automatic random_phase(int drain_at);
    kind_t            k;
    logic [CNT_W-1:0] fw;
    logic [31:0]      count;
    int               w;
    int               n_codes;
    int               target;
    k = kind_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       fw = 6'd0;
      1:       fw = CNT_W'($urandom_range(33, 63));
      default: fw = CNT_W'($urandom_range(1, 32));
    endcase
    w = (fw == 0) ? 1 : ((fw > 32) ? 32 : fw);
    stream_bits.delete();
    n_codes = 0;
    target  = $urandom_range(2, 12) * 32;
    while (stream_bits.size() < target) begin
      if (k != KIND_FIELD && $urandom_range(0, 59) == 0) push_overflow(k);
      push_code(k, w, rand_value(k));
      n_codes++;
    end
    pack_words();
    foreach (word_q[i]) if ($urandom_range(0, 11) == 0) word_q[i] = $urandom;
    case ($urandom_range(0, 9))
      0:       count = 32'd0;
      1, 2, 3: count = $urandom_range(1, n_codes);
      4, 5, 6: count = 32'hFFFF_FFFF;
      default: count = $urandom;
    endcase
    configure(k, fw, count, $urandom_range(0, 7) == 0);
    run_words($urandom_range(0, 4) == 0, drain_at);
  endtask

  initial begin
    int unsigned base;
    bit          first;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_word = '0;
    out_stall    = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: a single gamma zero, then the stream is ignored.
    word_q = '{32'h8000_0000, $urandom};
    run_words(1'b0, -1);

    // Unary: a word of ones, the longest legal prefix, then prefix overflow.
    configure(KIND_UNARY, 6'd32, 32'hFFFF_FFFF, 1'b0);
    word_q = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF};
    run_words(1'b0, -1);

    // Gamma extremes spanning words, ending in a prefix overflow.
    configure(KIND_GAMMA, 6'd32, 32'hFFFF_FFFF, 1'b0);
    stream_bits.delete();
    push_code(KIND_GAMMA, 32, 32'd0);
    push_code(KIND_GAMMA, 32, 32'd1);
    push_code(KIND_GAMMA, 32, 32'hFFFF_FFFE);
    push_code(KIND_GAMMA, 32, 32'd2);
    push_code(KIND_GAMMA, 32, 32'h0000_FFFF);
    push_zeros(32);
    pack_words();
    run_words(1'b1, -1);

    // Delta: the count runs out on the fourth value, the fifth is dropped.
    configure(KIND_DELTA, 6'd32, 32'd4, 1'b0);
    stream_bits.delete();
    push_code(KIND_DELTA, 32, 32'd0);
    push_code(KIND_DELTA, 32, 32'hFFFF_FFFE);
    push_code(KIND_DELTA, 32, 32'd1);
    push_code(KIND_DELTA, 32, 32'd5);
    push_code(KIND_DELTA, 32, 32'd30);
    pack_words();
    run_words(1'b0, -1);

    // Delta length of exactly 32 is an error.
    configure(KIND_DELTA, 6'd32, 32'hFFFF_FFFF, 1'b0);
    stream_bits.delete();
    push_zeros(5);
    push_bits(32'd33, 6);
    pack_words();
    run_words(1'b0, -1);

    // Overflow of the gamma prefix inside a delta code.
    configure(KIND_DELTA, 6'd32, 32'hFFFF_FFFF, 1'b0);
    word_q = '{32'h0000_0000};
    run_words(1'b0, -1);

    // Fixed fields at full width.
    configure(KIND_FIELD, 6'd32, 32'hFFFF_FFFF, 1'b0);
    word_q = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom};
    run_words(1'b0, -1);

    // A zero width reads as one bit per field.
    configure(KIND_FIELD, 6'd0, 32'd40, 1'b1);
    word_q = '{32'hA5A5_A5A5, 32'h5A5A_5A5A};
    run_words(1'b1, -1);

    // Width above 32 saturates.
    configure(KIND_FIELD, 6'd63, 32'd2, 1'b0);
    word_q = '{32'h1234_5678, 32'hFFFF_FFFF, $urandom};
    run_words(1'b0, -1);

    // A zero count decodes nothing.
    configure(KIND_GAMMA, 6'd1, 32'd0, 1'b0);
    word_q = '{32'h8000_0000};
    run_words(1'b0, -1);

    base  = sb.words_seen;
    first = 1'b1;
    while (sb.words_seen < base + RANDOM_WORDS) begin
      random_phase(first ? 1 : -1);
      first = 1'b0;
    end

    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.decoded_q.size() == 0) begin
      $display("elias_gamma_delta_decoder_unit test passed");
    end else begin
      $display("elias_gamma_delta_decoder_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/egdd_pkg.sv
hw/rtl/egdd_ctrl.sv
hw/rtl/egdd_dp.sv
hw/rtl/elias_gamma_delta_decoder_unit.sv
tb/sv/tb.sv
